/* hw/rtl/fpa_pkg.sv */
package fpa_pkg;

  localparam int FRAC_WIDTH_DEF = 8;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_LT  = 4'd4,
    OP_GT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13
  } opcode_t;

  typedef struct packed {
    logic               valid;
    logic [3:0]         op;
    logic [31:0]        val;
    logic               cmp;
    logic               dz;
    logic               neg;
    logic signed [63:0] prod;
    logic [31:0]        d;
    logic [63:0]        n;
    logic [32:0]        rem;
    logic [31:0]        q;
  } pkt_t;

endpackage

/* hw/rtl/fpa_prep.sv */
module fpa_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_pkg::pkt_t      pkt_out
);
  import fpa_pkg::*;

  pkt_t        pkt_r;
  pkt_t        pkt_nxt;
  logic        lt;
  logic        gt;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  assign lt    = operand_a < operand_b;
  assign gt    = operand_b < operand_a;
  assign mag_a = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
  assign mag_b = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

  always_comb begin
    pkt_nxt       = '0;
    pkt_nxt.valid = accept;
    pkt_nxt.op    = opcode;
    pkt_nxt.neg   = operand_a[31] ^ operand_b[31];
    pkt_nxt.prod  = 64'(operand_a) * 64'(operand_b);
    pkt_nxt.d     = mag_b;
    pkt_nxt.n     = {mag_a, 32'd0};
    pkt_nxt.dz    = (opcode == OP_DIV) && (operand_b == 32'sd0);
    unique case (opcode)
      OP_ADD: pkt_nxt.val = operand_a + operand_b;
      OP_SUB: pkt_nxt.val = operand_a - operand_b;
      OP_LT:  pkt_nxt.cmp = lt;
      OP_GT:  pkt_nxt.cmp = gt;
      OP_GE:  pkt_nxt.cmp = !lt;
      OP_LE:  pkt_nxt.cmp = !gt;
      OP_EQ:  pkt_nxt.cmp = operand_a == operand_b;
      OP_NE:  pkt_nxt.cmp = operand_a != operand_b;
      OP_MIN: pkt_nxt.val = gt ? operand_b : operand_a;
      OP_MAX: pkt_nxt.val = lt ? operand_b : operand_a;
      OP_INC: pkt_nxt.val = operand_a + 32'sd1;
      OP_DEC: pkt_nxt.val = operand_a - 32'sd1;
      default: pkt_nxt.val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= '0;
    end else begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

/* hw/rtl/fpa_div_stage.sv */
module fpa_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  fpa_pkg::pkt_t pkt_in,
  output fpa_pkg::pkt_t pkt_out
);
  import fpa_pkg::*;

  pkt_t        pkt_r;
  pkt_t        pkt_nxt;
  logic [32:0] rem_sh;
  logic        fits;

  // One restoring division step: bring down the next dividend bit.
  assign rem_sh = {pkt_in.rem[31:0], pkt_in.n[63]};
  assign fits   = rem_sh >= {1'b0, pkt_in.d};

  always_comb begin
    pkt_nxt     = pkt_in;
    pkt_nxt.n   = {pkt_in.n[62:0], 1'b0};
    pkt_nxt.rem = fits ? (rem_sh - {1'b0, pkt_in.d}) : rem_sh;
    pkt_nxt.q   = {pkt_in.q[30:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= '0;
    end else begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

/* hw/rtl/fixed_point_alu.sv */
// Signed 32-bit fixed-point ALU, fully pipelined: one operation is taken every
// cycle (busy stays low) and its result appears on the out_ ports for exactly
// one cycle, marked by out_valid, after passing the prep register, the divider
// stages and the output register. The divider resolves one quotient bit per
// pipeline stage over the 32 + FRAC_WIDTH bits of the shifted dividend; every
// opcode travels the same pipeline so results leave in order. The receiver
// cannot stall the block, so results must be captured when out_valid is high.
module fixed_point_alu #(
  parameter int FRAC_WIDTH = fpa_pkg::FRAC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_compare_true,
  output logic               out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int DIV_STEPS = WORD_W + FRAC_WIDTH;

  pkt_t               chain [DIV_STEPS+1];
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_cmp_r;
  logic               out_dz_r;
  logic signed [31:0] value_nxt;
  logic signed [63:0] prod_sh;
  pkt_t               last;

  assign busy = 1'b0;

  fpa_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start && !busy),
    .opcode   (in_opcode),
    .operand_a(in_operand_a),
    .operand_b(in_operand_b),
    .pkt_out  (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .pkt_in (chain[i]),
      .pkt_out(chain[i+1])
    );
  end

  assign last    = chain[DIV_STEPS];
  assign prod_sh = $signed(last.prod) >>> FRAC_WIDTH;

  always_comb begin
    case (last.op)
      OP_MUL: value_nxt = prod_sh[31:0];
      OP_DIV: value_nxt = last.dz ? 32'sd0 : (last.neg ? (~last.q + 32'd1) : last.q);
      default: value_nxt = last.val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
    out_value_r <= value_nxt;
    out_cmp_r   <= last.cmp;
    out_dz_r    <= last.dz;
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_compare_true   = out_cmp_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

/* hw/rtl/fpa_checker.sv */
module fpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_value,
  input logic               out_compare_true,
  input logic               out_divide_by_zero
);

  // The pipeline never holds off a new operation.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // A division by zero yields zero and no comparison flag.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_value == 32'sd0 && !out_compare_true)
    else $error("divide by zero result not clean");

  // A true comparison carries a zero value.
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_value == 32'sd0)
    else $error("comparison result carries a value");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_value         (out_value),
  .out_compare_true  (out_compare_true),
  .out_divide_by_zero(out_divide_by_zero)
);

/* dv/alu_checker.sv */
module alu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic               out_valid,
  input  logic signed [31:0] out_value,
  input  logic               out_compare_true,
  input  logic               out_divide_by_zero,
  output int                 fail_count,
  output int                 pending_count
);
  import fpa_pkg::*;

  localparam int FB = FRAC_WIDTH_DEF;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  alu_result_t result_queue[$];

  function automatic alu_result_t compute_alu(logic [3:0] op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic [63:0] na;
    logic [63:0] nb;
    logic [63:0] q;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FB);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          na = a[31] ? 64'(-64'(a)) : 64'(a);
          nb = b[31] ? 64'(-64'(b)) : 64'(b);
          q = (na << FB) / nb;
          if (a[31] ^ b[31]) q = -q;
          r.value = q[31:0];
        end
      end
      OP_LT: r.cmp = a < b;
      OP_GT: r.cmp = a > b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = (b < a) ? b : a;
      OP_MAX: r.value = (a < b) ? b : a;
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n) begin
      if (start && !busy)
        result_queue.push_back(compute_alu(in_opcode, in_operand_a, in_operand_b));
      if (out_valid) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected beat", out_value, 32'h0);
        end else begin
          want = result_queue.pop_front();
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_compare_true !== want.cmp)
            report_mismatch("compare_true", 32'(out_compare_true), 32'(want.cmp));
          if (out_divide_by_zero !== want.dz)
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(want.dz));
        end
      end
      pending_count = result_queue.size();
    end
  end
endmodule

/* dv/testbench.sv */
module testbench;
  import fpa_pkg::*;

  localparam int LATENCY = 34 + FRAC_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_opcode = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_value;
  logic out_compare_true;
  logic out_divide_by_zero;
  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_point_alu dut (.*);

  alu_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(0);
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      4: return 32'($signed($urandom_range(0, 511)) << 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_ops(int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                        : 4'($urandom_range(0, 13));
      send_op(op, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int op = 0; op < 16; op++)
      send_op(4'(op), 32'h7fff_ffff, 32'h8000_0000);
    send_op(OP_DIV, 32'h0000_0100, 32'h0);
    send_op(OP_MIN, 32'h1234_5678, 32'h1234_5678);
    send_op(OP_MAX, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(OP_DEC, 32'h8000_0000, 32'h0);
    send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    idle_pct = 7;
    random_ops(210);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    idle_pct = 82;
    random_ops(210);
    idle_pct = 0;
    random_ops(210);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
